// ----- design/dap_pkg.sv -----
// ----------------------------------------------------------------------------
// dap_pkg
// shared types, constants and character codes of the decimal amount parser
// ----------------------------------------------------------------------------
package dap_pkg;

    localparam int VALUE_BITS = 256;
    localparam int MAX_DIGITS = 77;
    localparam int WORD_W     = 64;
    localparam int NUM_WORDS  = (VALUE_BITS + WORD_W - 1) / WORD_W;
    localparam int IDX_W      = 2;
    localparam int CNT_W      = 7;
    localparam int CHAR_W     = 8;
    localparam int CARRY_W    = 4;

    // width of the most significant word that is kept
    localparam int TOP_BITS = VALUE_BITS - (NUM_WORDS - 1) * WORD_W;
    localparam logic [WORD_W-1:0] TOP_MASK = {WORD_W{1'b1}} >> (WORD_W - TOP_BITS);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_WORDS - 1);

    localparam logic [CNT_W-1:0] FRAC_RESET = 7'd18;
    localparam logic [CNT_W-1:0] DIGIT_LIM  = CNT_W'(MAX_DIGITS);
    localparam logic [CNT_W-1:0] CNT_SAT    = {CNT_W{1'b1}};

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_WHOLE,
        PH_FRAC,
        PH_TRAIL
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FINISH,
        ST_WORDS,
        ST_ERROR
    } seq_state_t;

    // request from the character decoder to the sequencer
    typedef struct packed {
        logic               mul_req;
        logic [CARRY_W-1:0] digit;
    } ctrl_t;

    // end of string verdict
    typedef struct packed {
        logic bad;
        logic pad_needed;
    } verdict_t;

endpackage

// ----- design/dap_if.sv -----
// ----------------------------------------------------------------------------
// dap_if
// valid/ready channels for characters in and amount words out
// ----------------------------------------------------------------------------
interface dap_char_if;
    logic                      valid;
    logic                      ready;
    logic [dap_pkg::CHAR_W-1:0] char_code;
    logic                      has_char;
    logic                      end_of_string;

    modport source (output valid, output char_code, output has_char,
                    output end_of_string, input ready);
    modport sink   (input valid, input char_code, input has_char,
                    input end_of_string, output ready);
endinterface

interface dap_word_if;
    logic                       valid;
    logic                       ready;
    logic [dap_pkg::WORD_W-1:0] value_word;
    logic [1:0]                 word_index;
    logic                       parse_ok;
    logic                       last_word;

    modport source (output valid, output value_word, output word_index,
                    output parse_ok, output last_word, input ready);
    modport sink   (input valid, input value_word, input word_index,
                    input parse_ok, input last_word, output ready);
endinterface

// ----- design/decimal_amount_parser_top.sv -----
// ----------------------------------------------------------------------------
// decimal_amount_parser_top
// decimal amount string to 256-bit integer scaled by 10^fraction_digits
// ----------------------------------------------------------------------------
// a non-digit character is taken while idle; a digit is worked by the single
//   multiply-by-ten adder walking the accumulator words in turn
// end of string: a verdict, then one multiply-by-ten pass per missing
//   fraction place, then NUM_WORDS result words (one error word on reject)
// no new character is taken while a digit or the result words are in work
// reset: asynchronous active low, parser cleared, fraction_digits back to 18
// ----------------------------------------------------------------------------
module decimal_amount_parser_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    dap_char_if.sink                    chars,
    dap_word_if.source                  amount,
    input  logic                        cfg_we,
    input  logic [dap_pkg::CNT_W-1:0]   cfg_wdata
);

    // sequencer state
    dap_pkg::seq_state_t              state_reg, state_next;
    logic [dap_pkg::IDX_W-1:0]        step_reg, step_next;
    logic [dap_pkg::CARRY_W-1:0]      carry_reg, carry_next;
    logic                             end_reg, end_next;
    logic [dap_pkg::CNT_W-1:0]        frac_digits_reg;

    // accumulator, held as a rotating line: word 0 is always the one in work
    logic [dap_pkg::WORD_W-1:0]       acc_reg  [dap_pkg::NUM_WORDS];
    logic [dap_pkg::WORD_W-1:0]       acc_next [dap_pkg::NUM_WORDS];

    // shared unit
    logic [dap_pkg::WORD_W-1:0]       mul_word;
    logic [dap_pkg::CARRY_W-1:0]      mul_carry;
    logic                             is_last;

    // decoder hookup
    logic                             in_accept;
    logic                             out_accept;
    logic                             take;
    logic                             pad_step;
    logic                             clear;
    dap_pkg::ctrl_t                   req;
    dap_pkg::verdict_t                verdict;

    assign is_last    = (step_reg == dap_pkg::LAST_IDX);
    assign chars.ready = (state_reg == dap_pkg::ST_IDLE);
    assign in_accept  = chars.valid && chars.ready;
    assign out_accept = amount.valid && amount.ready;

    dap_mul10 u_mul10
    (
        .word_in   (acc_reg[0]),
        .carry_in  (carry_reg),
        .is_top    (is_last),
        .word_out  (mul_word),
        .carry_out (mul_carry)
    );

    dap_ctrl u_ctrl
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (take),
        .char_code       (chars.char_code),
        .fraction_digits (frac_digits_reg),
        .pad_step        (pad_step),
        .clear           (clear),
        .req             (req),
        .verdict         (verdict)
    );

    // result word straight from the accumulator head
    assign amount.valid      = (state_reg == dap_pkg::ST_WORDS)
                            || (state_reg == dap_pkg::ST_ERROR);
    assign amount.value_word = (state_reg == dap_pkg::ST_WORDS) ? acc_reg[0] : '0;
    assign amount.word_index = (state_reg == dap_pkg::ST_WORDS) ? 2'(step_reg) : 2'd0;
    assign amount.parse_ok   = (state_reg == dap_pkg::ST_WORDS);
    assign amount.last_word  = (state_reg == dap_pkg::ST_ERROR) || is_last;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        carry_next = carry_reg;
        end_next   = end_reg;
        acc_next   = acc_reg;
        take       = 1'b0;
        pad_step   = 1'b0;
        clear      = 1'b0;

        case (state_reg)
            dap_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    take     = chars.has_char;
                    end_next = chars.end_of_string;
                    if (req.mul_req)
                    begin
                        carry_next = req.digit;
                        step_next  = '0;
                        state_next = dap_pkg::ST_MUL;
                    end
                    else if (chars.end_of_string)
                        state_next = dap_pkg::ST_FINISH;
                end
            end
            dap_pkg::ST_MUL:
            begin
                // one word per cycle, carry ripples up through carry_reg
                for (int i = 0; i < dap_pkg::NUM_WORDS - 1; i++)
                    acc_next[i] = acc_reg[i+1];
                acc_next[dap_pkg::NUM_WORDS-1] = mul_word;
                carry_next = mul_carry;
                if (is_last)
                begin
                    step_next  = '0;
                    state_next = end_reg ? dap_pkg::ST_FINISH : dap_pkg::ST_IDLE;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            dap_pkg::ST_FINISH:
            begin
                step_next = '0;
                if (verdict.bad)
                    state_next = dap_pkg::ST_ERROR;
                else if (verdict.pad_needed)
                begin
                    // fill a missing fraction place with a zero digit
                    pad_step   = 1'b1;
                    carry_next = '0;
                    state_next = dap_pkg::ST_MUL;
                end
                else
                    state_next = dap_pkg::ST_WORDS;
            end
            dap_pkg::ST_WORDS:
            begin
                if (out_accept)
                begin
                    // rotating zeros in leaves the accumulator cleared
                    for (int i = 0; i < dap_pkg::NUM_WORDS - 1; i++)
                        acc_next[i] = acc_reg[i+1];
                    acc_next[dap_pkg::NUM_WORDS-1] = '0;
                    if (is_last)
                    begin
                        clear      = 1'b1;
                        end_next   = 1'b0;
                        step_next  = '0;
                        state_next = dap_pkg::ST_IDLE;
                    end
                    else
                        step_next = step_reg + 1'b1;
                end
            end
            dap_pkg::ST_ERROR:
            begin
                if (out_accept)
                begin
                    for (int i = 0; i < dap_pkg::NUM_WORDS; i++)
                        acc_next[i] = '0;
                    clear      = 1'b1;
                    end_next   = 1'b0;
                    state_next = dap_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dap_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dap_pkg::ST_IDLE;
            step_reg        <= '0;
            carry_reg       <= '0;
            end_reg         <= 1'b0;
            frac_digits_reg <= dap_pkg::FRAC_RESET;
            for (int i = 0; i < dap_pkg::NUM_WORDS; i++)
                acc_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            carry_reg <= carry_next;
            end_reg   <= end_next;
            acc_reg   <= acc_next;
            if (cfg_we)
                frac_digits_reg <= cfg_wdata;
        end
    end

endmodule

// ----- design/dap_mul10.sv -----
// ----------------------------------------------------------------------------
// dap_mul10
// shared multiply-by-ten-and-add step on one accumulator word
// ----------------------------------------------------------------------------
module dap_mul10
(
    input  logic [dap_pkg::WORD_W-1:0]  word_in,
    input  logic [dap_pkg::CARRY_W-1:0] carry_in,
    input  logic                        is_top,
    output logic [dap_pkg::WORD_W-1:0]  word_out,
    output logic [dap_pkg::CARRY_W-1:0] carry_out
);

    logic [dap_pkg::WORD_W+dap_pkg::CARRY_W-1:0] wide;
    logic [dap_pkg::WORD_W+dap_pkg::CARRY_W-1:0] sum;

    assign wide = {{dap_pkg::CARRY_W{1'b0}}, word_in};

    // 10*w = 8*w + 2*w, carry is at most nine
    assign sum = (wide << 3) + (wide << 1)
               + {{dap_pkg::WORD_W{1'b0}}, carry_in};

    assign word_out  = is_top ? (sum[dap_pkg::WORD_W-1:0] & dap_pkg::TOP_MASK)
                              : sum[dap_pkg::WORD_W-1:0];
    assign carry_out = sum[dap_pkg::WORD_W+dap_pkg::CARRY_W-1:dap_pkg::WORD_W];

endmodule

// ----- design/dap_ctrl.sv -----
// ----------------------------------------------------------------------------
// dap_ctrl
// character decoder: parse phase, error flag and digit counters
// ----------------------------------------------------------------------------
module dap_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic [dap_pkg::CHAR_W-1:0] char_code,
    input  logic [dap_pkg::CNT_W-1:0]  fraction_digits,
    input  logic                       pad_step,
    input  logic                       clear,
    output dap_pkg::ctrl_t             req,
    output dap_pkg::verdict_t          verdict
);

    dap_pkg::phase_t            phase_reg, phase_next;
    logic                       failed_reg, failed_next;
    logic                       saw_reg, saw_next;
    logic [dap_pkg::CNT_W-1:0]  whole_reg, whole_next;
    logic [dap_pkg::CNT_W-1:0]  frac_reg, frac_next;
    logic [dap_pkg::CNT_W-1:0]  limit;
    logic                       is_digit;
    logic                       is_point;
    logic                       is_space;

    always_comb
    begin
        is_digit = char_code inside {[dap_pkg::CH_ZERO:dap_pkg::CH_NINE]};
        is_point = (char_code == dap_pkg::CH_POINT);
        is_space = (char_code == dap_pkg::CH_SPACE)
                || (char_code inside {[dap_pkg::CH_TAB:dap_pkg::CH_CR]});
    end

    always_comb
    begin
        phase_next  = phase_reg;
        failed_next = failed_reg;
        saw_next    = saw_reg;
        whole_next  = whole_reg;
        frac_next   = frac_reg;
        req.mul_req = 1'b0;
        req.digit   = dap_pkg::CARRY_W'(char_code - dap_pkg::CH_ZERO);

        if (clear)
        begin
            phase_next  = dap_pkg::PH_LEAD;
            failed_next = 1'b0;
            saw_next    = 1'b0;
            whole_next  = '0;
            frac_next   = '0;
        end
        else if (pad_step)
        begin
            frac_next = frac_reg + 1'b1;
        end
        else if (take && !failed_reg)
        begin
            if (char_code == dap_pkg::CH_NUL)
            begin
                failed_next = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    dap_pkg::PH_LEAD, dap_pkg::PH_WHOLE:
                    begin
                        if (is_space)
                        begin
                            if (phase_reg == dap_pkg::PH_WHOLE)
                                phase_next = dap_pkg::PH_TRAIL;
                        end
                        else if (is_digit)
                        begin
                            phase_next  = dap_pkg::PH_WHOLE;
                            saw_next    = 1'b1;
                            req.mul_req = 1'b1;
                            if (whole_reg != dap_pkg::CNT_SAT)
                                whole_next = whole_reg + 1'b1;
                        end
                        else if (is_point)
                        begin
                            phase_next = dap_pkg::PH_FRAC;
                            saw_next   = 1'b1;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    dap_pkg::PH_FRAC:
                    begin
                        if (is_space)
                            phase_next = dap_pkg::PH_TRAIL;
                        else if (is_digit && (frac_reg < fraction_digits))
                        begin
                            req.mul_req = 1'b1;
                            frac_next   = frac_reg + 1'b1;
                        end
                        else
                            failed_next = 1'b1;
                    end
                    default:
                    begin
                        if (!is_space)
                            failed_next = 1'b1;
                    end
                endcase
            end
        end
    end

    // whole digit budget left over by the fraction places
    assign limit = (fraction_digits >= dap_pkg::DIGIT_LIM) ? '0
                 : dap_pkg::DIGIT_LIM - fraction_digits;

    assign verdict.bad        = failed_reg || !saw_reg || (whole_reg > limit);
    assign verdict.pad_needed = frac_reg < fraction_digits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= dap_pkg::PH_LEAD;
            failed_reg <= 1'b0;
            saw_reg    <= 1'b0;
            whole_reg  <= '0;
            frac_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            failed_reg <= failed_next;
            saw_reg    <= saw_next;
            whole_reg  <= whole_next;
            frac_reg   <= frac_next;
        end
    end

endmodule

// ----- design/dap_checker.sv -----
// ----------------------------------------------------------------------------
// dap_checker
// port level checks of the decimal amount parser, bound to the top level
// ----------------------------------------------------------------------------
module dap_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [dap_pkg::WORD_W-1:0] value_word,
    input logic [1:0]                 word_index,
    input logic                       parse_ok,
    input logic                       last_word
);

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_word)
            && $stable(word_index) && $stable(parse_ok) && $stable(last_word))
        else $error("stalled word changed");

    // no character taken while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready while result pending");

    // a reject is one zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !parse_ok |-> last_word && (value_word == '0) && (word_index == 2'd0))
        else $error("malformed error word");

    // an accepted amount ends on the top word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_ok && last_word |-> word_index == 2'(dap_pkg::NUM_WORDS - 1))
        else $error("amount ended early");

    // words of one amount follow back to back in order
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=>
            out_valid && parse_ok && (word_index == 2'($past(word_index) + 2'd1)))
        else $error("word sequence broken");

endmodule

bind decimal_amount_parser_top dap_checker u_dap_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (chars.ready),
    .out_valid  (amount.valid),
    .out_ready  (amount.ready),
    .value_word (amount.value_word),
    .word_index (amount.word_index),
    .parse_ok   (amount.parse_ok),
    .last_word  (amount.last_word)
);

// ----- tb/decimal_amount_parser_top_tb.sv -----
// ----------------------------------------------------------------------------
// decimal_amount_parser_top_tb
// self-checking bench: amount strings in, scaled 256-bit amounts out
// ----------------------------------------------------------------------------
// character words come from a queue that the stimulus block fills, one string
// after another, and are offered in bursts with random gaps; every accepted
// character word feeds a bit-true parser model that queues the amount words
// it expects. the receiver stalls on a pattern of its own, once for a long
// stretch, and every amount word it takes is compared field by field with
// the oldest expected word. the decimal setting is changed only when the
// parser is idle, and runs from zero through to the top of the register
// ----------------------------------------------------------------------------
module decimal_amount_parser_top_tb;

    // run control
    localparam int CYCLE_LIMIT   = 500_000;
    localparam int SETTLE_CYCLES = 4 * (1 + dap_pkg::NUM_WORDS);
    localparam int LONG_HOLD     = 300;

    // byte outside every class the parser knows
    localparam logic [dap_pkg::CHAR_W-1:0] CH_HIGH = 8'hFF;

    // one character word as offered to the parser
    typedef struct packed {
        logic [dap_pkg::CHAR_W-1:0] code;
        logic                       has_char;
        logic                       eos;
    } char_item_t;

    // one amount word as given by the parser
    typedef struct packed {
        logic [dap_pkg::WORD_W-1:0] value;
        logic [dap_pkg::IDX_W-1:0]  index;
        logic                       ok;
        logic                       last;
    } amount_word_t;

    // receiver behaviour, picked afresh whenever the current mode runs out
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_RARELY,
        RDY_PATTERN
    } rdy_mode_t;

    // ways a well-formed amount gets broken
    typedef enum logic [1:0] {
        DMG_NUL,
        DMG_BLANK,
        DMG_POINT,
        DMG_BYTE
    } damage_t;

    logic clk;
    logic rst_n;
    logic                      cfg_we    = 1'b0;
    logic [dap_pkg::CNT_W-1:0] cfg_wdata = '0;

    dap_char_if chars_if ();
    dap_word_if amount_if ();

    decimal_amount_parser_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_if),
        .amount    (amount_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // stimulus to driver, model to checker
    char_item_t   pending_chars[$];
    amount_word_t expected_words[$];

    // parser model state, a copy of what the block should hold
    logic [dap_pkg::CNT_W-1:0]      frac_places = dap_pkg::FRAC_RESET;
    dap_pkg::phase_t                scan_phase  = dap_pkg::PH_LEAD;
    bit                             scan_failed = 1'b0;
    logic [dap_pkg::VALUE_BITS-1:0] amount_acc  = '0;
    logic [dap_pkg::CNT_W-1:0]      whole_seen  = '0;
    logic [dap_pkg::CNT_W-1:0]      frac_seen   = '0;
    bit                             body_seen   = 1'b0;

    // bookkeeping
    int stim_items       = 0;
    int chars_accepted   = 0;
    int strings_parsed   = 0;
    int strings_rejected = 0;
    int words_checked    = 0;
    int mismatches       = 0;
    int reg_writes       = 0;
    int holds_wanted     = 0;
    int holds_done       = 0;
    int cycle_count      = 0;

    // ------------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    function automatic bit is_blank(input logic [dap_pkg::CHAR_W-1:0] c);
        return c == dap_pkg::CH_SPACE || (c >= dap_pkg::CH_TAB && c <= dap_pkg::CH_CR);
    endfunction

    // one decimal step, wrapping at the amount width
    function automatic void acc_times_ten_plus(input logic [dap_pkg::CHAR_W-1:0] d);
        amount_acc = amount_acc * dap_pkg::VALUE_BITS'(10) + dap_pkg::VALUE_BITS'(d);
    endfunction

    function automatic void clear_scan();
        scan_phase  = dap_pkg::PH_LEAD;
        scan_failed = 1'b0;
        amount_acc  = '0;
        whole_seen  = '0;
        frac_seen   = '0;
        body_seen   = 1'b0;
    endfunction

    function automatic void amount_take_char(input logic [dap_pkg::CHAR_W-1:0] c);
        bit is_digit;
        bit is_point;
        bit blank;
        is_digit = c >= dap_pkg::CH_ZERO && c <= dap_pkg::CH_NINE;
        is_point = c == dap_pkg::CH_POINT;
        blank    = is_blank(c);
        // once rejected, everything up to the end is ignored
        if (scan_failed)
            return;
        if (c == dap_pkg::CH_NUL)
        begin
            scan_failed = 1'b1;
            return;
        end
        case (scan_phase)
            dap_pkg::PH_LEAD, dap_pkg::PH_WHOLE:
            begin
                if (blank)
                begin
                    // whitespace after whole digits closes the body
                    if (scan_phase == dap_pkg::PH_WHOLE)
                        scan_phase = dap_pkg::PH_TRAIL;
                end
                else if (is_digit)
                begin
                    scan_phase = dap_pkg::PH_WHOLE;
                    body_seen  = 1'b1;
                    acc_times_ten_plus(c - dap_pkg::CH_ZERO);
                    if (whole_seen != dap_pkg::CNT_SAT)
                        whole_seen++;
                end
                else if (is_point)
                begin
                    scan_phase = dap_pkg::PH_FRAC;
                    body_seen  = 1'b1;
                end
                else
                    scan_failed = 1'b1;
            end
            dap_pkg::PH_FRAC:
            begin
                if (blank)
                    scan_phase = dap_pkg::PH_TRAIL;
                else if (is_digit && frac_seen < frac_places)
                begin
                    acc_times_ten_plus(c - dap_pkg::CH_ZERO);
                    frac_seen++;
                end
                else
                    scan_failed = 1'b1;
            end
            default:
            begin
                if (!blank)
                    scan_failed = 1'b1;
            end
        endcase
    endfunction

    // end of string: verdict, padding of missing places, words queued
    function automatic void amount_close();
        logic [dap_pkg::CNT_W-1:0]                     whole_max;
        logic [dap_pkg::NUM_WORDS*dap_pkg::WORD_W-1:0] padded;
        amount_word_t                                  w;
        int                                            n;
        int                                            k;
        whole_max = (frac_places >= dap_pkg::DIGIT_LIM) ? '0
                  : dap_pkg::DIGIT_LIM - frac_places;
        if (!body_seen || whole_seen > whole_max)
            scan_failed = 1'b1;
        if (scan_failed)
        begin
            w = '{value: '0, index: '0, ok: 1'b0, last: 1'b1};
            expected_words.push_back(w);
            strings_rejected++;
        end
        else
        begin
            for (n = int'(frac_seen); n < int'(frac_places); n++)
                acc_times_ten_plus('0);
            padded                            = '0;
            padded[dap_pkg::VALUE_BITS-1:0]   = amount_acc;
            for (k = 0; k < dap_pkg::NUM_WORDS; k++)
            begin
                w.value = padded[k*dap_pkg::WORD_W +: dap_pkg::WORD_W];
                w.index = dap_pkg::IDX_W'(k);
                w.ok    = 1'b1;
                w.last  = (k == dap_pkg::NUM_WORDS - 1);
                expected_words.push_back(w);
            end
            strings_parsed++;
        end
        clear_scan();
    endfunction

    // ------------------------------------------------------------------------
    // character driver: bursts of words with random gaps between them
    // ------------------------------------------------------------------------
    char_item_t on_bus;
    int         burst_left = 0;
    int         gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin : char_driver
        bit take;
        if (!rst_n)
        begin
            chars_if.valid         <= 1'b0;
            chars_if.char_code     <= '0;
            chars_if.has_char      <= 1'b0;
            chars_if.end_of_string <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            take = chars_if.valid && chars_if.ready;
            // the model sees exactly the words the parser takes
            if (take)
            begin
                chars_accepted++;
                if (on_bus.has_char)
                    amount_take_char(on_bus.code);
                if (on_bus.eos)
                    amount_close();
            end
            // a word on offer stays put until taken
            if (!chars_if.valid || take)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    chars_if.valid <= 1'b0;
                end
                else if (pending_chars.size() > 0)
                begin
                    on_bus = pending_chars.pop_front();
                    chars_if.valid         <= 1'b1;
                    chars_if.char_code     <= on_bus.code;
                    chars_if.has_char      <= on_bus.has_char;
                    chars_if.end_of_string <= on_bus.eos;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        // now and then a long burst with no idling at all
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(0, 8);
                        gap_left   = $urandom_range(1, 6);
                    end
                end
                else
                    chars_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: own stall pattern, plus the long hold-off when asked for
    // ------------------------------------------------------------------------
    rdy_mode_t ready_mode  = RDY_ALWAYS;
    int        mode_left   = 0;
    int        hold_left   = 0;
    int        pattern_pos = 0;

    always @(posedge clk or negedge rst_n)
    begin : word_ready
        if (!rst_n)
        begin
            amount_if.ready <= 1'b0;
            mode_left = 0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            amount_if.ready <= 1'b0;
        end
        else if (holds_done < holds_wanted && amount_if.valid)
        begin
            // sit on a pending word so the parser backs up into its input
            holds_done++;
            hold_left = LONG_HOLD;
            amount_if.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = rdy_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(8, 64);
            end
            else
                mode_left--;
            pattern_pos++;
            case (ready_mode)
                RDY_ALWAYS:  amount_if.ready <= 1'b1;
                RDY_MOSTLY:  amount_if.ready <= ($urandom_range(0, 3) != 0);
                RDY_RARELY:  amount_if.ready <= ($urandom_range(0, 4) == 0);
                default:     amount_if.ready <= (pattern_pos % 3 != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // checker: each amount word against the oldest expected word
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name,
                                        input logic [dap_pkg::WORD_W-1:0] want,
                                        input logic [dap_pkg::WORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : word_monitor
        amount_word_t got;
        amount_word_t want;
        if (rst_n && amount_if.valid && amount_if.ready)
        begin
            got = '{value: amount_if.value_word, index: amount_if.word_index,
                    ok: amount_if.parse_ok, last: amount_if.last_word};
            words_checked++;
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected amount word, expected none, got %h/%0d/%0b/%0b",
                         $time, got.value, got.index, got.ok, got.last);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                check_field("value_word", want.value, got.value);
                check_field("word_index", dap_pkg::WORD_W'(want.index),
                            dap_pkg::WORD_W'(got.index));
                check_field("parse_ok", dap_pkg::WORD_W'(want.ok), dap_pkg::WORD_W'(got.ok));
                check_field("last_word", dap_pkg::WORD_W'(want.last),
                            dap_pkg::WORD_W'(got.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [dap_pkg::CHAR_W-1:0] c, input bit has,
                             input bit eos);
        pending_chars.push_back(char_item_t'{code: c, has_char: has, eos: eos});
        // empty words do nothing in the parser, so they are not counted
        if (has || eos)
            stim_items++;
    endtask

    // one string; the end rides on the last character or on an end-only word
    task automatic send_bytes(input logic [dap_pkg::CHAR_W-1:0] text[$], input bit split_end);
        int i;
        for (i = 0; i < text.size(); i++)
        begin
            if ($urandom_range(0, 15) == 0)
                push_item(dap_pkg::CHAR_W'($urandom), 1'b0, 1'b0);
            push_item(text[i], 1'b1, !split_end && i == text.size() - 1);
        end
        if (split_end || text.size() == 0)
            push_item(dap_pkg::CHAR_W'($urandom), 1'b0, 1'b1);
    endtask

    task automatic send_text(input string s, input bit split_end);
        logic [dap_pkg::CHAR_W-1:0] text[$];
        int                         i;
        for (i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        send_bytes(text, split_end);
    endtask

    function automatic logic [dap_pkg::CHAR_W-1:0] pick_blank();
        return ($urandom_range(0, 1) == 1) ? dap_pkg::CH_SPACE
             : dap_pkg::CHAR_W'($urandom_range(dap_pkg::CH_TAB, dap_pkg::CH_CR));
    endfunction

    // mostly well-formed amounts with random content, some broken, some noise
    task automatic gen_string(input int places);
        logic [dap_pkg::CHAR_W-1:0] text[$];
        logic [dap_pkg::CHAR_W-1:0] bad;
        int                         whole_max;
        int                         n_whole;
        int                         n_frac;
        int                         r;
        int                         i;
        bit                         with_point;
        bit                         nines;
        damage_t                    dmg;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            repeat ($urandom_range(1, 4)) text.push_back(dap_pkg::CHAR_W'($urandom));
        end
        else
        begin
            whole_max = (places >= dap_pkg::MAX_DIGITS) ? 0 : dap_pkg::MAX_DIGITS - places;
            nines     = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
            // rarely the full whole-digit allowance, or one past it
            r = $urandom_range(0, 99);
            if (r < 2)
                n_whole = whole_max;
            else if (r < 4)
                n_whole = whole_max + 1;
            else
                n_whole = $urandom_range(0, (whole_max < 6) ? whole_max : 6);
            with_point = (n_whole == 0) ? ($urandom_range(0, 7) != 0)
                                        : ($urandom_range(0, 1) == 1);
            for (i = 0; i < n_whole; i++)
                text.push_back(nines ? dap_pkg::CH_NINE
                             : dap_pkg::CH_ZERO + dap_pkg::CHAR_W'($urandom_range(0, 9)));
            if (with_point)
            begin
                text.push_back(dap_pkg::CH_POINT);
                r = $urandom_range(0, 99);
                if (r < 5)
                    n_frac = places + 1;
                else if (r < 12)
                    n_frac = places;
                else
                    n_frac = $urandom_range(0, (places < 4) ? places : 4);
                for (i = 0; i < n_frac; i++)
                    text.push_back(nines ? dap_pkg::CH_NINE
                                 : dap_pkg::CH_ZERO + dap_pkg::CHAR_W'($urandom_range(0, 9)));
            end
            repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
            if ($urandom_range(0, 99) < 25)
            begin
                dmg = damage_t'($urandom_range(0, 3));
                case (dmg)
                    DMG_NUL:   bad = dap_pkg::CH_NUL;
                    DMG_BLANK: bad = pick_blank();
                    DMG_POINT: bad = dap_pkg::CH_POINT;
                    default:   bad = dap_pkg::CHAR_W'($urandom);
                endcase
                text.insert($urandom_range(0, text.size()), bad);
            end
        end
        send_bytes(text, $urandom_range(0, 3) == 0);
    endtask

    // parser idle: nothing queued, nothing on offer, nothing owed
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_chars.size() != 0 || chars_if.valid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_places(input int places);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= dap_pkg::CNT_W'(places);
        @(posedge clk);
        cfg_we    <= 1'b0;
        frac_places = dap_pkg::CNT_W'(places);
        reg_writes++;
    endtask

    task automatic run_phase(input int places, input int budget, input bit squeeze);
        int target;
        wait_idle();
        write_places(places);
        if (squeeze)
            holds_wanted++;
        target = stim_items + budget;
        while (stim_items < target)
            gen_string(places);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [dap_pkg::CHAR_W-1:0] raw[$];

        wait (rst_n === 1'b1);
        @(negedge clk);

        // directed part at the reset setting of 18 places
        send_text("", 1'b1);            // empty string
        send_text(" ", 1'b0);           // whitespace only
        send_text(".", 1'b0);           // lone point, parses as zero
        raw = '{dap_pkg::CH_NUL};
        send_bytes(raw, 1'b0);          // nul byte
        raw = '{CH_HIGH};
        send_bytes(raw, 1'b0);          // top byte value, not a digit
        send_text("1 2", 1'b0);         // space inside the body
        send_text("1..", 1'b0);         // second point
        send_text("x", 1'b0);           // stray letter
        send_text("\t0.5\v", 1'b1);     // whitespace both sides, split end

        // no fraction places: any fraction digit is too many
        wait_idle();
        write_places(0);
        send_text("1.0", 1'b0);
        send_text("7", 1'b0);

        // top of the range: a single whole digit allowed
        wait_idle();
        write_places(76);
        send_text("12", 1'b0);
        send_text("9.", 1'b0);

        // random part, several settings including both ends and beyond 77
        run_phase(18, 90, 1'b0);
        run_phase(0, 70, 1'b0);
        run_phase(5, 70, 1'b1);
        run_phase(76, 40, 1'b0);
        run_phase(127, 20, 1'b0);
        run_phase(dap_pkg::MAX_DIGITS, 20, 1'b0);
        run_phase($urandom_range(1, 75), 90, 1'b0);

        wait_idle();

        $display("covered %0d character words in %0d strings (%0d parsed, %0d rejected)",
                 chars_accepted, strings_parsed + strings_rejected, strings_parsed,
                 strings_rejected);
        $display("%0d decimal settings written, %0d amount words checked, %0d long holds",
                 reg_writes, words_checked, holds_done);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: no progress after %0d cycles, %0d words still expected",
                 $time, cycle_count, expected_words.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
